// ----- rtl/psx_pkg.sv -----
// Shared types, constants and helpers for the polyline stroke expander.
`default_nettype none

package psx_pkg;

	// Field widths
	localparam int CoordW    = 32;
	localparam int PrevW     = 16;
	localparam int HalfW     = 12;
	localparam int LimitW    = 16;
	localparam int TotalW    = 17;
	localparam int CfgIdxW   = 1;
	localparam int CfgDataW  = 16;

	// Arithmetic widths
	localparam int MagW      = 31;   // shifted step magnitude
	localparam int RootW     = 32;   // floor of the step length
	localparam int QuotW     = 28;   // offset magnitude, at most half width * 2^16
	localparam int SqrtSteps = 32;
	localparam int DivSteps  = 28;
	localparam int CntW      = 5;

	// Register indexes
	localparam logic [CfgIdxW-1:0] CfgHalfWidth   = 1'b0;
	localparam logic [CfgIdxW-1:0] CfgVertexLimit = 1'b1;

	localparam logic [HalfW-1:0]  HalfWidthReset  = 12'd1;
	localparam logic [LimitW-1:0] VertexLimReset  = 16'd64;
	localparam logic [TotalW-1:0] VertexTotalMax  = 17'h1FFFF;
	localparam logic [TotalW-1:0] VertsPerPoint   = 17'd2;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic sqr;
		logic sum;
		logic sqrt_step;
		logic mul;
		logic div_step;
		logic finish;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic special;
		logic out_free;
	} sts_t;

	// Clamp a 33-bit signed sum to the signed 32-bit range
	function automatic logic [CoordW-1:0] sat33(input logic signed [CoordW:0] v);
		logic [CoordW-1:0] r;
		if (v[CoordW] != v[CoordW-1])
			r = v[CoordW] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
		else
			r = v[CoordW-1:0];
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/psx_ctrl.sv -----
// Sequencing state machine for the stroke expander.
`default_nettype none

module psx_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire psx_pkg::sts_t  sts,
	output psx_pkg::cmd_t       cmd
);
	import psx_pkg::*;

	typedef enum logic [6:0] {
		IDLE = 7'b0000001,
		SQR  = 7'b0000010,
		SUM  = 7'b0000100,
		SQRT = 7'b0001000,
		MUL  = 7'b0010000,
		DIV  = 7'b0100000,
		DONE = 7'b1000000
	} state_t;

	state_t          state_q, state_d;
	logic [CntW-1:0] cnt_q, cnt_d;

	assign in_ready = (state_q == IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		case (state_q)
			IDLE: begin
				cmd.load = in_valid;
				if (in_valid)
					state_d = SQR;
			end
			SQR: begin
				cmd.sqr = 1'b1;
				state_d = sts.special ? DONE : SUM;
			end
			SUM: begin
				cmd.sum = 1'b1;
				cnt_d   = CntW'(SqrtSteps - 1);
				state_d = SQRT;
			end
			SQRT: begin
				cmd.sqrt_step = 1'b1;
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == '0)
					state_d = MUL;
			end
			MUL: begin
				cmd.mul = 1'b1;
				cnt_d   = CntW'(DivSteps - 1);
				state_d = DIV;
			end
			DIV: begin
				cmd.div_step = 1'b1;
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == '0)
					state_d = DONE;
			end
			DONE: begin
				cmd.finish = sts.out_free;
				if (sts.out_free)
					state_d = IDLE;
			end
			default: state_d = IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/psx_dp.sv -----
// Datapath: point state, square root, dividers and output register.
`default_nettype none

module psx_dp (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire psx_pkg::cmd_t                    cmd,
	output psx_pkg::sts_t                         sts,
	input  wire logic signed [psx_pkg::CoordW-1:0] point_x,
	input  wire logic signed [psx_pkg::CoordW-1:0] point_y,
	input  wire logic                             cfg_valid,
	input  wire logic [psx_pkg::CfgIdxW-1:0]      cfg_index,
	input  wire logic [psx_pkg::CfgDataW-1:0]     cfg_data,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic signed [psx_pkg::CoordW-1:0]     left_x,
	output logic signed [psx_pkg::CoordW-1:0]     left_y,
	output logic signed [psx_pkg::CoordW-1:0]     right_x,
	output logic signed [psx_pkg::CoordW-1:0]     right_y,
	output logic                                  first_point,
	output logic                                  replaces_oldest,
	output logic                                  degenerate
);
	import psx_pkg::*;

	// Configuration and persistent state
	logic [HalfW-1:0]  half_q;
	logic [LimitW-1:0] limit_q;
	logic              have_prev_q;
	logic [PrevW-1:0]  prev_x_q, prev_y_q;
	logic [TotalW-1:0] total_q;

	// Per-item working registers
	logic [CoordW-1:0] x_q, y_q;
	logic [MagW-1:0]   a_q, b_q;
	logic              dx_neg_q, dy_neg_q, first_q, repl_q, degen_q;
	logic [2*MagW-1:0] aa_q, bb_q;
	logic [63:0]       rad_q;
	logic [RootW:0]    srem_q;
	logic [RootW-1:0]  root_q, len_q;
	logic [RootW-1:0]  remx_q, remy_q;
	logic [QuotW-1:0]  lowx_q, lowy_q, qx_q, qy_q;

	// Step from the truncated previous point
	logic signed [CoordW+1:0] dx, dy, ndx, ndy;
	logic [CoordW:0]          ax, ay;
	logic                     big, repl_in;
	logic [PrevW-1:0]         px_t, py_t;

	always_comb begin
		dx  = (CoordW+2)'(point_x) - $signed({{2{prev_x_q[PrevW-1]}}, prev_x_q, 16'b0});
		dy  = (CoordW+2)'(point_y) - $signed({{2{prev_y_q[PrevW-1]}}, prev_y_q, 16'b0});
		ndx = -dx;
		ndy = -dy;
		ax  = dx[CoordW+1] ? ndx[CoordW:0] : dx[CoordW:0];
		ay  = dy[CoordW+1] ? ndy[CoordW:0] : dy[CoordW:0];
		big = ax[CoordW] | ax[CoordW-1] | ay[CoordW] | ay[CoordW-1];
		// truncate toward zero to whole units
		px_t = point_x[31:16] + PrevW'(point_x[31] && (point_x[15:0] != '0));
		py_t = point_y[31:16] + PrevW'(point_y[31] && (point_y[15:0] != '0));
		repl_in = have_prev_q && (total_q > {1'b0, limit_q});
	end

	// Square root step, two radicand bits per cycle
	logic [RootW+2:0] r_t, trial, r_sub;
	logic             r_ge;
	always_comb begin
		r_t   = {srem_q, rad_q[63:62]};
		trial = {1'b0, root_q, 2'b01};
		r_sub = r_t - trial;
		r_ge  = (r_t >= trial);
	end

	// Divider lanes, one quotient bit each per cycle
	logic [RootW:0]   tx, ty, tx_sub, ty_sub;
	logic             gx, gy;
	logic [RootW-1:0] len_in;
	logic [HalfW+MagW-1:0] pbx, pby;
	always_comb begin
		tx     = {remx_q, lowx_q[QuotW-1]};
		ty     = {remy_q, lowy_q[QuotW-1]};
		tx_sub = tx - {1'b0, len_q};
		ty_sub = ty - {1'b0, len_q};
		gx     = (tx >= {1'b0, len_q});
		gy     = (ty >= {1'b0, len_q});
		len_in = (root_q == '0) ? RootW'(1) : root_q;
		pbx    = half_q * b_q;
		pby    = half_q * a_q;
	end

	// Final offsets and saturation
	logic signed [CoordW:0] ox, oy, xs, ys;
	logic [CoordW-1:0]      rx, ry, lx, ly;
	always_comb begin
		ox = $signed({{(CoordW+1-QuotW){1'b0}}, qx_q});
		oy = $signed({{(CoordW+1-QuotW){1'b0}}, qy_q});
		if (dy_neg_q) ox = -ox;
		if (dx_neg_q) oy = -oy;
		xs = $signed({x_q[CoordW-1], x_q});
		ys = $signed({y_q[CoordW-1], y_q});
		rx = sat33(xs + ox);
		lx = sat33(xs - ox);
		ry = sat33(ys - oy);
		ly = sat33(ys + oy);
	end

	assign sts = '{special: first_q | degen_q, out_free: !out_valid || out_ready};

	// Configuration and persistent state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q      <= HalfWidthReset;
			limit_q     <= VertexLimReset;
			have_prev_q <= 1'b0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			total_q     <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CfgHalfWidth:   half_q  <= cfg_data[HalfW-1:0];
					CfgVertexLimit: limit_q <= cfg_data[LimitW-1:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				have_prev_q <= 1'b1;
				prev_x_q    <= px_t;
				prev_y_q    <= py_t;
				if (!repl_in)
					total_q <= (total_q >= VertexTotalMax - VertsPerPoint) ?
						VertexTotalMax : total_q + VertsPerPoint;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q      <= point_x;
			y_q      <= point_y;
			a_q      <= big ? ax[CoordW-1:1] : ax[MagW-1:0];
			b_q      <= big ? ay[CoordW-1:1] : ay[MagW-1:0];
			dx_neg_q <= dx[CoordW+1];
			dy_neg_q <= dy[CoordW+1];
			first_q  <= !have_prev_q;
			repl_q   <= repl_in;
			degen_q  <= have_prev_q && (dx == '0) && (dy == '0);
		end
		if (cmd.sqr) begin
			aa_q <= a_q * a_q;
			bb_q <= b_q * b_q;
		end
		if (cmd.sum) begin
			rad_q  <= {1'b0, 63'(aa_q) + 63'(bb_q)};
			srem_q <= '0;
			root_q <= '0;
		end
		if (cmd.sqrt_step) begin
			rad_q  <= {rad_q[61:0], 2'b00};
			srem_q <= r_ge ? r_sub[RootW:0] : r_t[RootW:0];
			root_q <= {root_q[RootW-2:0], r_ge};
		end
		if (cmd.mul) begin
			len_q  <= len_in;
			remx_q <= {1'b0, pbx[HalfW+MagW-1:12]};
			remy_q <= {1'b0, pby[HalfW+MagW-1:12]};
			lowx_q <= {pbx[11:0], 16'b0};
			lowy_q <= {pby[11:0], 16'b0};
			qx_q   <= '0;
			qy_q   <= '0;
		end
		if (cmd.div_step) begin
			remx_q <= gx ? tx_sub[RootW-1:0] : tx[RootW-1:0];
			remy_q <= gy ? ty_sub[RootW-1:0] : ty[RootW-1:0];
			lowx_q <= {lowx_q[QuotW-2:0], 1'b0};
			lowy_q <= {lowy_q[QuotW-2:0], 1'b0};
			qx_q   <= {qx_q[QuotW-2:0], gx};
			qy_q   <= {qy_q[QuotW-2:0], gy};
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (cmd.finish)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			left_x          <= sts.special ? x_q : lx;
			left_y          <= sts.special ? y_q : ly;
			right_x         <= sts.special ? x_q : rx;
			right_y         <= sts.special ? y_q : ry;
			first_point     <= first_q;
			replaces_oldest <= repl_q;
			degenerate      <= degen_q;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/polyline_stroke_expander_top.sv -----
// Top level of the polyline stroke expander.
`default_nettype none

// Turns each Q16.16 trail point into the left and right vertices of a thick
// line strip, offset perpendicular to the step from the previous point
// (truncated to whole units) by the configured half width. An ordinary point
// passes through two setup steps (squaring and summing), a square root (two
// radicand bits per cycle), a multiply, a divider with one lane per axis and
// a move into the output register, which waits until that register is free.
// The first point after reset and a zero-length step skip both units and go
// straight from the squaring step to the output register. The next point is
// accepted the cycle after the current one has moved to the output register,
// even if that result has not yet been taken, but never before that move.
// Configuration writes are always ready and must be issued while the block
// is idle.
module polyline_stroke_expander_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic signed [psx_pkg::CoordW-1:0] point_x,
	input  wire logic signed [psx_pkg::CoordW-1:0] point_y,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic signed [psx_pkg::CoordW-1:0]     left_x,
	output logic signed [psx_pkg::CoordW-1:0]     left_y,
	output logic signed [psx_pkg::CoordW-1:0]     right_x,
	output logic signed [psx_pkg::CoordW-1:0]     right_y,
	output logic                                  first_point,
	output logic                                  replaces_oldest,
	output logic                                  degenerate,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [psx_pkg::CfgIdxW-1:0]      cfg_index,
	input  wire logic [psx_pkg::CfgDataW-1:0]     cfg_data
);
	import psx_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	psx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	psx_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.point_x         (point_x),
		.point_y         (point_y),
		.cfg_valid       (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.left_x          (left_x),
		.left_y          (left_y),
		.right_x         (right_x),
		.right_y         (right_y),
		.first_point     (first_point),
		.replaces_oldest (replaces_oldest),
		.degenerate      (degenerate)
	);

`ifndef SYNTHESIS
	// one item at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while item in flight");

	// first point carries no other flag
	a_first_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && first_point |-> !degenerate && !replaces_oldest)
		else $error("first point with extra flag");

	// degenerate and first points collapse both vertices
	a_collapse: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (degenerate || first_point) |->
			left_x == right_x && left_y == right_y)
		else $error("collapsed point with distinct vertices");
`endif

endmodule

`default_nettype wire
